### hw/rtl/flow_signature_classifier_assert.svh
// Assertion macros used by the checker file of the classifier.
`ifndef FLOW_SIGNATURE_CLASSIFIER_ASSERT_SVH
`define FLOW_SIGNATURE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, quiet while reset is high
`define FSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is high
`define FSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset
`define FSC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/fsc_pkg.sv
package fsc_pkg;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  // Verdict codes
  typedef enum logic [1:0] {
    VERDICT_UNDECIDED = 2'd0,
    VERDICT_DETECTED  = 2'd1,
    VERDICT_EXCLUDED  = 2'd2
  } verdict_t;

  // Transport codes
  localparam logic [1:0] TRANSPORT_UDP = 2'd1;
  localparam logic [1:0] TRANSPORT_TCP = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_CONFIRM_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_UDP_MISS_LIMIT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TCP_MISS_LIMIT    = 2'd2;

  // Configuration reset values
  localparam logic [7:0] CONFIRM_THRESHOLD_RST = 8'd3;
  localparam logic [7:0] UDP_MISS_LIMIT_RST    = 8'd24;
  localparam logic [7:0] TCP_MISS_LIMIT_RST    = 8'd4;

  // One packet event
  typedef struct packed {
    logic        new_flow;
    logic [1:0]  transport;
    logic [15:0] payload_length;
    logic [63:0] head_low;
    logic [47:0] head_high;
    logic [7:0]  byte_thirty_two;
    logic        source_seen;
    logic        dest_seen;
  } fsc_item_t;

  // Per-flow state
  typedef struct packed {
    verdict_t   verdict;
    logic [7:0] confirm_count;
    logic [7:0] miss_count;
    logic [7:0] length_stage;
  } fsc_state_t;

  // Configuration registers
  typedef struct packed {
    logic [7:0] confirm_threshold;
    logic [7:0] udp_miss_limit;
    logic [7:0] tcp_miss_limit;
  } fsc_cfg_t;

  // Saturating increment at 255
  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hff) ? v : v + 8'd1;
  endfunction

endpackage

### hw/rtl/fsc_decide.sv
module fsc_decide (
  input  fsc_pkg::fsc_item_t  item,
  input  fsc_pkg::fsc_state_t state,
  input  fsc_pkg::fsc_cfg_t   cfg,
  output fsc_pkg::fsc_state_t state_next
);

  logic [111:0]         head;
  logic [7:0]           b [14];
  logic [7:0]           b32;
  logic [15:0]          len;
  logic                 both_seen;
  fsc_pkg::fsc_state_t  cur;
  fsc_pkg::fsc_state_t  nxt;
  logic [7:0]           cc_inc;
  logic [7:0]           mc_inc;
  logic [7:0]           ls1;
  logic [7:0]           ls2;
  fsc_pkg::verdict_t    hit_verdict;
  logic                 udp_a, udp_b, udp_c, udp_d;
  logic                 tcp_a, tcp_b, tcp_c, tcp_d, tcp_e;

  assign head      = {item.head_high, item.head_low};
  assign len       = item.payload_length;
  assign both_seen = item.source_seen & item.dest_seen;

  // Zero the bytes past the payload
  always_comb begin
    for (int i = 0; i < 14; i++) begin
      b[i] = (len > 16'(i)) ? head[8*i +: 8] : 8'h00;
    end
    b32 = (len > 16'd32) ? item.byte_thirty_two : 8'h00;
  end

  // Signature matches
  assign udp_a = (b[0] == 8'h28) && (b[1] == 8'h28) && (b[3] == 8'h00) &&
                 (b[5] == 8'h08) && (b[8] == 8'h01) && (b[9] == 8'h18);
  assign udp_b = (b[0] == 8'h75) && (b[1] == 8'h75) && (b[8] == 8'h00) &&
                 (b[9] == 8'hde);
  assign udp_c = (b[0] == 8'h13) && (b[1] == 8'hce) && (b[2] == 8'h00) &&
                 (b[3] == 8'h04);
  assign udp_d = (b[0] == 8'h01) && (b[1] == 8'h00) && (b[2] == 8'h00) &&
                 (b[3] == 8'h00) && (b[4] == 8'h00) && (b32 == 8'h08);
  assign tcp_a = (b[0] == 8'h33) && (b[1] == 8'h66) && (b[2] == 8'h00) &&
                 (b[3] == 8'h0a) && (b[4] == 8'h00) && (b[5] == 8'h0a);
  assign tcp_b = (b[0] == 8'h50) && (b[1] == 8'h0a) && (b[2] == 8'h00) &&
                 (b[3] == 8'h00) && (b[4] == 8'h00) && (b[5] == 8'h01) &&
                 (b[9] == 8'h91);
  assign tcp_c = (b[0] == 8'h43) && (b[1] == 8'h66) && (b[2] == 8'haa) &&
                 (b[3] == 8'h00) && (b[4] == 8'h00) && (b[5] == 8'h00) &&
                 (b[7] == 8'h15);
  assign tcp_d = (b[0] == 8'haa) && (b[1] == 8'h00) && (b[2] == 8'h00) &&
                 (b[3] == 8'h00) && (b[5] == 8'h15) && (b[6] == 8'h00) &&
                 (b[7] == 8'h00);
  assign tcp_e = (b[0] == 8'h01) && (b[1] == 8'h00) && (b[2] == 8'h00);

  // Start of a new flow clears the state first
  assign cur = item.new_flow ? fsc_pkg::fsc_state_t'('0) : state;

  assign cc_inc      = fsc_pkg::sat_inc(cur.confirm_count);
  assign mc_inc      = fsc_pkg::sat_inc(cur.miss_count);
  assign hit_verdict = (cc_inc >= cfg.confirm_threshold) ? fsc_pkg::VERDICT_DETECTED
                                                         : cur.verdict;

  // Length run stage: first the 25/23/210 run, then the 33-byte run
  always_comb begin
    if (len == 16'd25) begin
      ls1 = fsc_pkg::sat_inc(cur.length_stage);
    end else if ((len == 16'd23) && (cur.length_stage >= 8'd4)) begin
      ls1 = fsc_pkg::sat_inc(cur.length_stage);
    end else if ((len == 16'd210) && (cur.length_stage == 8'd6)) begin
      ls1 = fsc_pkg::sat_inc(cur.length_stage);
    end else if (cur.length_stage < 8'h10) begin
      ls1 = 8'd0;
    end else begin
      ls1 = cur.length_stage;
    end
    if (len != 16'd33) begin
      ls2 = ls1;
    end else if (udp_d) begin
      ls2 = 8'h11;
    end else if (ls1 >= 8'h11) begin
      ls2 = fsc_pkg::sat_inc(ls1);
    end else begin
      ls2 = ls1;
    end
  end

  // Pick the next flow state
  always_comb begin
    nxt = cur;
    if (cur.verdict == fsc_pkg::VERDICT_UNDECIDED) begin
      if ((item.transport == fsc_pkg::TRANSPORT_UDP) && (len >= 16'd10)) begin
        if (udp_a) begin
          nxt.confirm_count = cc_inc;
          nxt.verdict       = hit_verdict;
        end else begin
          nxt.length_stage = ls1;
          if (ls1 == 8'd7) begin
            nxt.verdict = fsc_pkg::VERDICT_DETECTED;
          end else if (udp_b || udp_c) begin
            nxt.confirm_count = cc_inc;
            nxt.verdict       = hit_verdict;
          end else begin
            nxt.length_stage = ls2;
            if ((len == 16'd33) && (ls2 >= 8'h14)) begin
              nxt.verdict = fsc_pkg::VERDICT_DETECTED;
            end else if (both_seen) begin
              nxt.verdict = fsc_pkg::VERDICT_DETECTED;
            end else begin
              nxt.miss_count = mc_inc;
              if (mc_inc >= cfg.udp_miss_limit) begin
                nxt.verdict = fsc_pkg::VERDICT_EXCLUDED;
              end
            end
          end
        end
      end else if ((item.transport == fsc_pkg::TRANSPORT_TCP) && (len >= 16'd8)) begin
        if (both_seen || tcp_b || (!tcp_a && !tcp_c && !tcp_d && tcp_e)) begin
          nxt.verdict = fsc_pkg::VERDICT_DETECTED;
        end else if (tcp_a || tcp_c || tcp_d) begin
          nxt.confirm_count = cc_inc;
          nxt.verdict       = hit_verdict;
        end else begin
          nxt.miss_count = mc_inc;
          if (mc_inc >= cfg.tcp_miss_limit) begin
            nxt.verdict = fsc_pkg::VERDICT_EXCLUDED;
          end
        end
      end
    end
  end

  assign state_next = nxt;

endmodule

### hw/rtl/flow_signature_classifier.sv
// Per-flow application classifier.
// Input stream (s_axis_*): one packet event per transfer. tuser carries the
// new-flow flag and the transport code, tdata the payload length, payload
// bytes 0 to 13, payload byte 32 and the two host-seen flags.
// Output stream (m_axis_*): one verdict per event, in order: undecided,
// detected or excluded, as held once that event has been applied.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (confirm threshold, UDP miss limit, TCP miss limit); write only while idle.
// Path: an accepted event goes into the input register, then its verdict into the
// result register. Throughput: one event per cycle while the verdict stream is not
// stalled, with the flow state updated by the decision logic as each event advances.
// Reset (rst, synchronous): clears the flow state and both stages and loads
// the default thresholds and limits.
// Stall: while m_axis_tready is low the verdict holds; one more event is
// still taken into the input register, after which s_axis_tready drops.
module flow_signature_classifier (
  input  logic                             clk,
  input  logic                             rst,
  // Packet event stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, low bit up: payload_length[15:0], head_low[63:0], head_high[47:0],
  // byte_thirty_two[7:0], source_seen, dest_seen, zero fill
  input  logic [fsc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser, low bit up: new_flow, transport[1:0]
  input  logic [fsc_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  // Verdict stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata, low bit up: verdict[1:0], zero fill
  output logic [fsc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [fsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                 in_valid;
  fsc_pkg::fsc_item_t   in_item;
  fsc_pkg::fsc_item_t   in_item_next;
  logic                 out_valid;
  fsc_pkg::verdict_t    out_verdict;
  fsc_pkg::fsc_state_t  flow;
  fsc_pkg::fsc_state_t  flow_next;
  fsc_pkg::fsc_cfg_t    cfg;
  logic                 advance;

  // Result register frees up when empty or taken
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  // Unpack the event
  always_comb begin
    in_item_next.new_flow        = s_axis_tuser[0];
    in_item_next.transport       = s_axis_tuser[2:1];
    in_item_next.payload_length  = s_axis_tdata[15:0];
    in_item_next.head_low        = s_axis_tdata[79:16];
    in_item_next.head_high       = s_axis_tdata[127:80];
    in_item_next.byte_thirty_two = s_axis_tdata[135:128];
    in_item_next.source_seen     = s_axis_tdata[136];
    in_item_next.dest_seen       = s_axis_tdata[137];
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= in_item_next;
    end
  end

  fsc_decide u_decide (
    .item       (in_item),
    .state      (flow),
    .cfg        (cfg),
    .state_next (flow_next)
  );

  // Flow state and result register advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      flow      <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        flow <= flow_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_verdict <= flow_next.verdict;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_verdict};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.confirm_threshold <= fsc_pkg::CONFIRM_THRESHOLD_RST;
      cfg.udp_miss_limit    <= fsc_pkg::UDP_MISS_LIMIT_RST;
      cfg.tcp_miss_limit    <= fsc_pkg::TCP_MISS_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fsc_pkg::CFG_CONFIRM_THRESHOLD: cfg.confirm_threshold <= cfg_data;
        fsc_pkg::CFG_UDP_MISS_LIMIT:    cfg.udp_miss_limit    <= cfg_data;
        fsc_pkg::CFG_TCP_MISS_LIMIT:    cfg.tcp_miss_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/fsc_checker.sv
`include "flow_signature_classifier_assert.svh"

module fsc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [fsc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // Hold a stalled verdict
  `FSC_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled verdict changed")

  // Keep the fill bits of the verdict at zero
  `FSC_ASSERT_NOW(a_out_fill, clk, rst, m_axis_tvalid,
    m_axis_tdata[7:2] == 6'd0, "verdict fill bits not zero")

  // An event taken while no verdict waits brings out a verdict after the input and result registers
  `FSC_ASSERT_NEXT(a_latency, clk, rst,
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid,
    ##1 m_axis_tvalid, "verdict missing after an accepted event")

  // Take events whenever no verdict is waiting
  `FSC_ASSERT_NOW(a_ready_empty, clk, rst, !m_axis_tvalid, s_axis_tready,
    "input stalled with an empty result register")

  // Drop the result after reset
  `FSC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_axis_tvalid,
    "verdict shown straight after reset")

endmodule

bind flow_signature_classifier fsc_checker u_fsc_checker (.*);

### dv/flow_signature_classifier_tb.sv
`timescale 1ns / 1ps

module flow_signature_classifier_tb;

  // Transport codes with no name in the package
  localparam logic [1:0] TRANSPORT_OTHER    = 2'd0;
  localparam logic [1:0] TRANSPORT_RESERVED = 2'd3;

  // Packet shapes the stimulus draws from
  typedef enum int {
    PK_UDP_CTRL,
    PK_UDP_ALT75,
    PK_UDP_ALT13,
    PK_UDP_LEN25,
    PK_UDP_LEN23,
    PK_UDP_LEN210,
    PK_UDP_RUN_START,
    PK_UDP_LEN33,
    PK_UDP_NOISE,
    PK_TCP_SIG33,
    PK_TCP_SIG50,
    PK_TCP_SIG43,
    PK_TCP_SIGAA,
    PK_TCP_SIG01,
    PK_TCP_NOISE,
    PK_OTHER
  } packet_kind_t;

  // Predicts the flow verdict and holds the verdicts still to arrive
  class verdict_tracker_t;
    fsc_pkg::fsc_cfg_t   limits;
    fsc_pkg::fsc_state_t flow;
    bit [7:0]            head [15];
    fsc_pkg::verdict_t   expected_verdicts [$];
    int unsigned         mismatches;

    function new();
      limits.confirm_threshold = fsc_pkg::CONFIRM_THRESHOLD_RST;
      limits.udp_miss_limit    = fsc_pkg::UDP_MISS_LIMIT_RST;
      limits.tcp_miss_limit    = fsc_pkg::TCP_MISS_LIMIT_RST;
      clear_flow();
      mismatches = 0;
    endfunction

    function void clear_flow();
      flow.verdict       = fsc_pkg::VERDICT_UNDECIDED;
      flow.confirm_count = 8'd0;
      flow.miss_count    = 8'd0;
      flow.length_stage  = 8'd0;
    endfunction

    function void write_limit(logic [fsc_pkg::CFG_INDEX_W-1:0] index, logic [7:0] value);
      case (index)
        fsc_pkg::CFG_CONFIRM_THRESHOLD: limits.confirm_threshold = value;
        fsc_pkg::CFG_UDP_MISS_LIMIT:    limits.udp_miss_limit    = value;
        fsc_pkg::CFG_TCP_MISS_LIMIT:    limits.tcp_miss_limit    = value;
        default: ;
      endcase
    endfunction

    function logic [7:0] bump(logic [7:0] v);
      return (v == 8'hff) ? v : v + 8'd1;
    endfunction

    function void score_hit();
      flow.confirm_count = bump(flow.confirm_count);
      if (flow.confirm_count >= limits.confirm_threshold)
        flow.verdict = fsc_pkg::VERDICT_DETECTED;
    endfunction

    function void score_miss(logic [7:0] limit);
      flow.miss_count = bump(flow.miss_count);
      if (flow.miss_count >= limit) flow.verdict = fsc_pkg::VERDICT_EXCLUDED;
    endfunction

    function void udp_event(logic [15:0] len, bit both_seen);
      if (len < 16'd10) return;
      if (head[0] == 8'h28 && head[1] == 8'h28 && head[3] == 8'h00 && head[5] == 8'h08 &&
          head[8] == 8'h01 && head[9] == 8'h18) begin
        score_hit();
        return;
      end
      // Length run: 25s, then 23s from stage four, then 210 at stage six
      if (len == 16'd25)
        flow.length_stage = bump(flow.length_stage);
      else if (len == 16'd23 && flow.length_stage >= 8'd4)
        flow.length_stage = bump(flow.length_stage);
      else if (len == 16'd210 && flow.length_stage == 8'd6)
        flow.length_stage = bump(flow.length_stage);
      else if (flow.length_stage < 8'h10)
        flow.length_stage = 8'd0;
      if (flow.length_stage == 8'd7) begin
        flow.verdict = fsc_pkg::VERDICT_DETECTED;
        return;
      end
      if ((head[0] == 8'h75 && head[1] == 8'h75 && head[8] == 8'h00 && head[9] == 8'hde) ||
          (head[0] == 8'h13 && head[1] == 8'hce && head[2] == 8'h00 && head[3] == 8'h04)) begin
        score_hit();
        return;
      end
      // 33-byte run starts at stage 17 and detects from stage 20
      if (len == 16'd33) begin
        if (head[0] == 8'h01 && head[1] == 8'h00 && head[2] == 8'h00 && head[3] == 8'h00 &&
            head[4] == 8'h00 && head[14] == 8'h08)
          flow.length_stage = 8'h11;
        else if (flow.length_stage >= 8'h11)
          flow.length_stage = bump(flow.length_stage);
        if (flow.length_stage >= 8'h14) begin
          flow.verdict = fsc_pkg::VERDICT_DETECTED;
          return;
        end
      end
      if (both_seen) begin
        flow.verdict = fsc_pkg::VERDICT_DETECTED;
        return;
      end
      score_miss(limits.udp_miss_limit);
    endfunction

    function void tcp_event(logic [15:0] len, bit both_seen);
      if (len < 16'd8) return;
      if (both_seen) begin
        flow.verdict = fsc_pkg::VERDICT_DETECTED;
        return;
      end
      if (head[0] == 8'h33 && head[1] == 8'h66 && head[2] == 8'h00 && head[3] == 8'h0a &&
          head[4] == 8'h00 && head[5] == 8'h0a) begin
        score_hit();
        return;
      end
      if (head[0] == 8'h50 && head[1] == 8'h0a && head[2] == 8'h00 && head[3] == 8'h00 &&
          head[4] == 8'h00 && head[5] == 8'h01 && head[9] == 8'h91) begin
        flow.verdict = fsc_pkg::VERDICT_DETECTED;
        return;
      end
      if ((head[0] == 8'h43 && head[1] == 8'h66 && head[2] == 8'haa && head[3] == 8'h00 &&
           head[4] == 8'h00 && head[5] == 8'h00 && head[7] == 8'h15) ||
          (head[0] == 8'haa && head[1] == 8'h00 && head[2] == 8'h00 && head[3] == 8'h00 &&
           head[5] == 8'h15 && head[6] == 8'h00 && head[7] == 8'h00)) begin
        score_hit();
        return;
      end
      if (head[0] == 8'h01 && head[1] == 8'h00 && head[2] == 8'h00) begin
        flow.verdict = fsc_pkg::VERDICT_DETECTED;
        return;
      end
      score_miss(limits.tcp_miss_limit);
    endfunction

    // Apply one accepted packet and queue the verdict it leaves behind
    function void note_packet(fsc_pkg::fsc_item_t p);
      int unsigned i;
      bit both_seen;
      for (i = 0; i < 8; i++) head[i] = p.head_low[8*i +: 8];
      for (i = 0; i < 6; i++) head[8+i] = p.head_high[8*i +: 8];
      // Bytes past the payload read as zero
      for (i = 0; i < 14; i++) if (p.payload_length <= 16'(i)) head[i] = 8'd0;
      head[14] = (p.payload_length > 16'd32) ? p.byte_thirty_two : 8'd0;
      both_seen = p.source_seen && p.dest_seen;
      if (p.new_flow) clear_flow();
      if (flow.verdict == fsc_pkg::VERDICT_UNDECIDED) begin
        if (p.transport == fsc_pkg::TRANSPORT_UDP)
          udp_event(p.payload_length, both_seen);
        else if (p.transport == fsc_pkg::TRANSPORT_TCP)
          tcp_event(p.payload_length, both_seen);
      end
      expected_verdicts.push_back(flow.verdict);
    endfunction

    function void check_verdict(logic [fsc_pkg::OUT_TDATA_W-1:0] word);
      fsc_pkg::verdict_t want;
      if (expected_verdicts.size() == 0) begin
        $error("verdict: no transfer expected, got %0d", word[1:0]);
        mismatches++;
        return;
      end
      want = expected_verdicts.pop_front();
      if (word[1:0] !== want) begin
        $error("verdict: expected %0d, got %0d", want, word[1:0]);
        mismatches++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // tdata, low bit up: payload_length[15:0], head_low[63:0], head_high[47:0],
  // byte_thirty_two[7:0], source_seen, dest_seen, zero fill
  logic [fsc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // tuser, low bit up: new_flow, transport[1:0]
  logic [fsc_pkg::IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // tdata, low bit up: verdict[1:0], zero fill
  logic [fsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_we = 1'b0;
  logic [fsc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [fsc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  verdict_tracker_t verdicts = new();
  bit               quiet_run = 1'b0;
  int unsigned      packets_sent = 0;

  flow_signature_classifier dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // Take verdict transfers, stalling now and then
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) verdicts.check_verdict(m_axis_tdata);
      m_axis_tready <= quiet_run || ($urandom_range(99) >= 15);
    end
  end

  // Build one packet of the given shape around random content
  function automatic fsc_pkg::fsc_item_t make_packet(packet_kind_t kind, bit first);
    fsc_pkg::fsc_item_t p;
    logic [7:0]         b [14];
    int                 i;
    for (i = 0; i < 14; i++) b[i] = 8'($urandom_range(255));
    p.new_flow        = first;
    p.transport       = fsc_pkg::TRANSPORT_UDP;
    p.payload_length  = ($urandom_range(9) < 7) ? 16'($urandom_range(64))
                                                : 16'($urandom_range(65535));
    p.byte_thirty_two = 8'($urandom_range(255));
    p.source_seen     = 1'($urandom_range(1));
    p.dest_seen       = p.source_seen ? ($urandom_range(3) == 0) : 1'($urandom_range(1));
    case (kind)
      PK_UDP_CTRL: begin
        b[0] = 8'h28; b[1] = 8'h28; b[3] = 8'h00; b[5] = 8'h08; b[8] = 8'h01; b[9] = 8'h18;
        p.payload_length = 16'($urandom_range(8, 64));
      end
      PK_UDP_ALT75: begin
        b[0] = 8'h75; b[1] = 8'h75; b[8] = 8'h00; b[9] = 8'hde;
        p.payload_length = 16'($urandom_range(8, 64));
      end
      PK_UDP_ALT13: begin
        b[0] = 8'h13; b[1] = 8'hce; b[2] = 8'h00; b[3] = 8'h04;
        p.payload_length = 16'($urandom_range(4, 64));
      end
      PK_UDP_LEN25:  p.payload_length = 16'd25;
      PK_UDP_LEN23:  p.payload_length = 16'd23;
      PK_UDP_LEN210: p.payload_length = 16'd210;
      PK_UDP_RUN_START: begin
        b[0] = 8'h01; b[1] = 8'h00; b[2] = 8'h00; b[3] = 8'h00; b[4] = 8'h00;
        p.byte_thirty_two = 8'h08;
        p.payload_length  = 16'd33;
      end
      PK_UDP_LEN33: p.payload_length = 16'd33;
      PK_UDP_NOISE: ;
      PK_TCP_SIG33: begin
        p.transport = fsc_pkg::TRANSPORT_TCP;
        b[0] = 8'h33; b[1] = 8'h66; b[2] = 8'h00; b[3] = 8'h0a; b[4] = 8'h00; b[5] = 8'h0a;
        p.payload_length = 16'($urandom_range(6, 40));
      end
      PK_TCP_SIG50: begin
        p.transport = fsc_pkg::TRANSPORT_TCP;
        b[0] = 8'h50; b[1] = 8'h0a; b[2] = 8'h00; b[3] = 8'h00; b[4] = 8'h00; b[5] = 8'h01;
        b[9] = 8'h91;
        p.payload_length = 16'($urandom_range(8, 40));
      end
      PK_TCP_SIG43: begin
        p.transport = fsc_pkg::TRANSPORT_TCP;
        b[0] = 8'h43; b[1] = 8'h66; b[2] = 8'haa; b[3] = 8'h00; b[4] = 8'h00; b[5] = 8'h00;
        b[7] = 8'h15;
        p.payload_length = 16'($urandom_range(8, 40));
      end
      PK_TCP_SIGAA: begin
        p.transport = fsc_pkg::TRANSPORT_TCP;
        b[0] = 8'haa; b[1] = 8'h00; b[2] = 8'h00; b[3] = 8'h00; b[5] = 8'h15; b[6] = 8'h00;
        b[7] = 8'h00;
        p.payload_length = 16'($urandom_range(8, 40));
      end
      PK_TCP_SIG01: begin
        p.transport = fsc_pkg::TRANSPORT_TCP;
        b[0] = 8'h01; b[1] = 8'h00; b[2] = 8'h00;
        // Long form carries 9c 8d 4c 42 at bytes 10 to 13
        if ($urandom_range(1)) begin
          b[10] = 8'h9c; b[11] = 8'h8d; b[12] = 8'h4c; b[13] = 8'h42;
        end
        p.payload_length = 16'($urandom_range(3, 64));
      end
      PK_TCP_NOISE: p.transport = fsc_pkg::TRANSPORT_TCP;
      default: p.transport = $urandom_range(1) ? TRANSPORT_RESERVED : TRANSPORT_OTHER;
    endcase
    for (i = 0; i < 8; i++) p.head_low[8*i +: 8] = b[i];
    for (i = 0; i < 6; i++) p.head_high[8*i +: 8] = b[8+i];
    return p;
  endfunction

  // Present one packet, idling first at random, and hold until it is taken
  task automatic send_packet(input fsc_pkg::fsc_item_t p);
    while (!quiet_run && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, p.dest_seen, p.source_seen, p.byte_thirty_two, p.head_high,
                      p.head_low, p.payload_length};
    s_axis_tuser  <= {p.transport, p.new_flow};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    verdicts.note_packet(p);
    packets_sent++;
  endtask

  // Stop sending and wait for every outstanding verdict
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (verdicts.expected_verdicts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all three limits while the block is idle
  task automatic apply_limits(input logic [7:0] thr, input logic [7:0] udp_lim,
                              input logic [7:0] tcp_lim);
    logic [fsc_pkg::CFG_INDEX_W-1:0] idx [3];
    logic [7:0]                      vals [3];
    int                              i;
    idx  = '{fsc_pkg::CFG_CONFIRM_THRESHOLD, fsc_pkg::CFG_UDP_MISS_LIMIT,
             fsc_pkg::CFG_TCP_MISS_LIMIT};
    vals = '{thr, udp_lim, tcp_lim};
    drain();
    for (i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      verdicts.write_limit(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One flow: mostly well-formed sequences, with broken steps and trailing packets
  task automatic run_flow();
    packet_kind_t plan [$];
    int           style;
    int           n;
    int           i;
    style = $urandom_range(5);
    case (style)
      0: plan = '{PK_UDP_LEN25, PK_UDP_LEN25, PK_UDP_LEN25, PK_UDP_LEN25,
                  PK_UDP_LEN23, PK_UDP_LEN23, PK_UDP_LEN210};
      1: plan = '{PK_UDP_RUN_START, PK_UDP_LEN33, PK_UDP_LEN33, PK_UDP_LEN33};
      2: begin
        n = $urandom_range(1, 6);
        repeat (n) plan.push_back(packet_kind_t'($urandom_range(PK_UDP_CTRL, PK_UDP_ALT13)));
      end
      3: begin
        n = $urandom_range(1, 6);
        repeat (n) plan.push_back(packet_kind_t'($urandom_range(PK_TCP_SIG33, PK_TCP_SIG01)));
      end
      4: begin
        n = $urandom_range(1, 30);
        repeat (n) plan.push_back($urandom_range(1) ? PK_UDP_NOISE : PK_TCP_NOISE);
      end
      default: begin
        n = $urandom_range(1, 12);
        repeat (n) plan.push_back(packet_kind_t'($urandom_range(PK_OTHER)));
      end
    endcase
    // Break some sequences
    if (style < 4)
      for (i = 0; i < plan.size(); i++)
        if ($urandom_range(99) < 15) plan[i] = packet_kind_t'($urandom_range(PK_OTHER));
    n = $urandom_range(3);
    repeat (n) plan.push_back(packet_kind_t'($urandom_range(PK_OTHER)));
    for (i = 0; i < plan.size(); i++)
      send_packet(make_packet(plan[i], (i == 0) && ($urandom_range(9) != 0)));
  endtask

  task automatic run_items(input int unsigned count);
    int unsigned target;
    target = packets_sent + count;
    while (packets_sent < target) run_flow();
  endtask

  initial begin : stimulus
    fsc_pkg::fsc_item_t p;
    int                 i;
    int unsigned        wait_cycles;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Counted hits up to the default threshold, then one past the verdict
    for (i = 0; i < 4; i++) send_packet(make_packet(PK_UDP_CTRL, i == 0));
    // Both hosts seen on TCP at the shortest length that counts
    p = make_packet(PK_TCP_NOISE, 1'b1);
    p.payload_length = 16'd8; p.source_seen = 1'b1; p.dest_seen = 1'b1;
    send_packet(p);
    // Short TCP is skipped even with both hosts seen
    p = make_packet(PK_TCP_NOISE, 1'b1);
    p.payload_length = 16'd7; p.source_seen = 1'b1; p.dest_seen = 1'b1;
    send_packet(p);
    // Signature byte 9 lies past a nine-byte payload
    p = make_packet(PK_TCP_SIG50, 1'b0);
    p.payload_length = 16'd9; p.source_seen = 1'b0;
    send_packet(p);
    // Other transports: one with random content, then one with every data field at its top
    p = make_packet(PK_OTHER, 1'b1);
    p.transport = TRANSPORT_OTHER;
    send_packet(p);
    p.new_flow = 1'b0; p.transport = TRANSPORT_RESERVED; p.payload_length = '1;
    p.head_low = '1; p.head_high = '1; p.byte_thirty_two = '1;
    p.source_seen = 1'b1; p.dest_seen = 1'b1;
    send_packet(p);
    // Empty UDP payload
    p = make_packet(PK_UDP_NOISE, 1'b0);
    p.payload_length = 16'd0;
    send_packet(p);
    // Long form of the 01 00 00 signature at the largest length
    p = make_packet(PK_TCP_SIG01, 1'b1);
    p.payload_length = 16'hffff; p.head_high[47:16] = 32'h424c8d9c; p.source_seen = 1'b0;
    send_packet(p);
    // Misses up to the default TCP limit
    for (i = 0; i < 4; i++) begin
      p = make_packet(PK_TCP_NOISE, i == 0);
      p.payload_length = 16'd8 + 16'(i); p.source_seen = 1'b0;
      send_packet(p);
    end
    // Length run through to detection
    send_packet(make_packet(PK_UDP_LEN25, 1'b1));
    repeat (3) send_packet(make_packet(PK_UDP_LEN25, 1'b0));
    repeat (2) send_packet(make_packet(PK_UDP_LEN23, 1'b0));
    send_packet(make_packet(PK_UDP_LEN210, 1'b0));
    // 33-byte run through to detection
    send_packet(make_packet(PK_UDP_RUN_START, 1'b1));
    repeat (3) send_packet(make_packet(PK_UDP_LEN33, 1'b0));

    apply_limits(fsc_pkg::CONFIRM_THRESHOLD_RST, fsc_pkg::UDP_MISS_LIMIT_RST,
                 fsc_pkg::TCP_MISS_LIMIT_RST);
    run_items(260);

    apply_limits(8'd1, 8'd1, 8'd1);
    run_items(260);

    // Long stretch with no idling on either side
    quiet_run = 1'b1;
    apply_limits(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                 8'($urandom_range(1, 255)));
    run_items(260);
    quiet_run = 1'b0;

    // Counters pinned at 255: confirm count and length stage, then miss count
    apply_limits(8'd255, 8'd255, 8'd255);
    p = make_packet(PK_UDP_RUN_START, 1'b1);
    p.source_seen = 1'b0;
    send_packet(p);
    repeat (255) begin
      p = make_packet(PK_UDP_ALT75, 1'b0);
      p.payload_length = 16'd25;
      send_packet(p);
    end
    for (i = 0; i < 255; i++) begin
      p = make_packet(PK_UDP_NOISE, i == 0);
      p.payload_length = 16'($urandom_range(34, 200)); p.dest_seen = 1'b0;
      send_packet(p);
    end
    run_items(200);

    // Zero limits: first counted hit detects, first miss excludes
    apply_limits(8'd0, 8'd0, 8'd0);
    run_items(150);

    apply_limits(8'($urandom_range(1, 255)), 8'($urandom_range(1, 8)),
                 8'($urandom_range(1, 8)));
    run_items(260);

    // Let the last verdicts come out
    s_axis_tvalid <= 1'b0;
    for (wait_cycles = 0; wait_cycles < 5000 && verdicts.expected_verdicts.size() != 0;
         wait_cycles++)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (verdicts.expected_verdicts.size() != 0) begin
      $error("verdict: %0d transfers never arrived", verdicts.expected_verdicts.size());
      verdicts.mismatches++;
    end
    if (verdicts.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
